// File: design/msss_pkg.sv
// ----------------------------------------------------------------------------
// msss_pkg: shared definitions for the multiplexed seven-segment scanner
// Holds sizes, command and register codes, the segment decode function and
// the control structures passed between the scanner's modules.
// ----------------------------------------------------------------------------
package msss_pkg;

    // Number of physical digit positions, one lane per position.
    localparam int MAX_DIGITS = 8;
    localparam int LANE_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W      = 4;
    localparam int BCD_W      = 32;
    localparam int NIBBLES    = BCD_W / 4;
    localparam int PERIOD_W   = 16;
    localparam int SEG_W      = 8;

    // Reset value of the digit count register.
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);

    // Dot segment.
    localparam logic [SEG_W-1:0] DOT_MASK = SEG_W'(1 << 7);

    // Commands carried in tuser.
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_REFRESH = 2'd1;
    localparam logic [1:0] CMD_TOGGLE  = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_DIGIT_COUNT  = 2'd0;
    localparam logic [1:0] REG_FLASH_FIRST  = 2'd1;
    localparam logic [1:0] REG_FLASH_LAST   = 2'd2;
    localparam logic [1:0] REG_FLASH_PERIOD = 2'd3;

    typedef logic [SEG_W-1:0] seg_t;

    // Command broadcast to all lanes for one accepted beat.
    typedef struct packed {
        logic             wr;
        logic             tog;
        logic [CNT_W-1:0] count;
        logic [BCD_W-1:0] bcd;
        logic [3:0]       total;
        logic [2:0]       rfirst;
        logic [2:0]       rlast;
    } lane_cmd_t;

    // Control from the top level to the scan and flash logic.
    typedef struct packed {
        logic             step;
        logic             count_wr;
        logic [CNT_W-1:0] count_new;
        logic             flash_clr;
    } scan_ctl_t;

    // Clamp the digit count register to 1..MAX_DIGITS.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw);
        logic [CNT_W-1:0] n;
        n = raw;
        if (n == '0)
        begin
            n = CNT_W'(1);
        end
        if (int'(n) > MAX_DIGITS)
        begin
            n = CNT_W'(MAX_DIGITS);
        end
        return n;
    endfunction

    // BCD to segments a..g; non-decimal codes are blank.
    function automatic seg_t seg_of(input logic [3:0] nib);
        seg_t s;
        case (nib)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// File: design/mux_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// mux_seven_segment_scanner: multiplexed seven-segment display scanner
// Per-digit lanes hold segment patterns, a scan stage drives one digit per
// refresh beat, and an APB port holds the count and flash settings.
// ----------------------------------------------------------------------------
// The block takes one command beat per clock cycle unless stalled: every
// command completes in the cycle it is accepted, the eight digit lanes
// updating in parallel and the scan stage selecting the active lane. Only a
// refresh beat produces an output beat, which is registered in an output
// register backed by a skid register; the input stalls only while both of
// them hold beats that the downstream side has not taken.
module mux_seven_segment_scanner (
    input  logic        clk,
    input  logic        rst_n,
    // Command stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] bcd_digits, [35:32] digit_total, [38:36] range_first,
    // [41:39] range_last, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    // Refresh output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] digit_select, [10:3] segments, [15:11] zero
    output logic [15:0] m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import msss_pkg::*;

    logic [CNT_W-1:0]    digit_count_reg;
    logic [2:0]          flash_first_reg;
    logic [2:0]          flash_last_reg;
    logic [PERIOD_W-1:0] flash_period_reg;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;
    logic                accept;
    logic [CNT_W-1:0]    count;
    lane_cmd_t           cmd;
    scan_ctl_t           ctl;
    seg_t                patterns [MAX_DIGITS];
    logic [2:0]          scan_sel;
    seg_t                scan_seg;
    logic                push;
    logic                pop;
    logic                out_valid_reg;
    logic [10:0]         out_data_reg;
    logic                skid_valid_reg;
    logic [10:0]         skid_data_reg;

    // Configuration writes and reads.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg  <= COUNT_RESET;
            flash_first_reg  <= '0;
            flash_last_reg   <= '0;
            flash_period_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_DIGIT_COUNT:  digit_count_reg  <= pwdata[CNT_W-1:0];
                REG_FLASH_FIRST:  flash_first_reg  <= pwdata[2:0];
                REG_FLASH_LAST:   flash_last_reg   <= pwdata[2:0];
                REG_FLASH_PERIOD: flash_period_reg <= pwdata[PERIOD_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_DIGIT_COUNT:  prdata = 32'(digit_count_reg);
            REG_FLASH_FIRST:  prdata = 32'(flash_first_reg);
            REG_FLASH_LAST:   prdata = 32'(flash_last_reg);
            REG_FLASH_PERIOD: prdata = 32'(flash_period_reg);
            default:          prdata = '0;
        endcase
    end

    // Decode the accepted beat into lane and scan controls.
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign count         = eff_count(digit_count_reg);

    always_comb
    begin
        cmd.wr     = accept && (s_axis_tuser == CMD_WRITE);
        cmd.tog    = accept && (s_axis_tuser == CMD_TOGGLE);
        cmd.count  = count;
        cmd.bcd    = s_axis_tdata[31:0];
        cmd.total  = s_axis_tdata[35:32];
        cmd.rfirst = s_axis_tdata[38:36];
        cmd.rlast  = s_axis_tdata[41:39];

        ctl.step      = accept && (s_axis_tuser == CMD_REFRESH);
        ctl.count_wr  = cfg_wr && (cfg_idx == REG_DIGIT_COUNT);
        ctl.count_new = eff_count(pwdata[CNT_W-1:0]);
        ctl.flash_clr = cfg_wr && (cfg_idx != REG_DIGIT_COUNT);
    end

    // One lane per physical digit.
    for (genvar g = 0; g < MAX_DIGITS; g++)
    begin : g_lane
        msss_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .lane_idx (LANE_W'(g)),
            .cmd      (cmd),
            .pattern  (patterns[g])
        );
    end

    msss_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .count        (count),
        .flash_first  (flash_first_reg),
        .flash_last   (flash_last_reg),
        .flash_period (flash_period_reg),
        .patterns     (patterns),
        .digit_select (scan_sel),
        .segments     (scan_seg)
    );

    // Output register with a skid register behind it.
    assign push = ctl.step;
    assign pop  = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= {scan_seg, scan_sel};
            end
            else
            begin
                skid_data_reg <= {scan_seg, scan_sel};
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};

    // The skid register only fills behind a full output register.
    a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat with output register empty");

    // A refresh beat taken with both registers free shows up next cycle.
    a_refresh_out: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !out_valid_reg) |=> (m_axis_tvalid && !skid_valid_reg))
        else $error("refresh beat did not reach the output register");

    // A stalled output beat is not lost when the skid register fills.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled output beat changed");

endmodule

// File: design/msss_lane.sv
// ----------------------------------------------------------------------------
// msss_lane: one physical digit position
// Holds the segment pattern of its position and applies write and dot
// toggle commands that fall on the logical digit mapped to it.
// ----------------------------------------------------------------------------
module msss_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [msss_pkg::LANE_W-1:0] lane_idx,
    input  msss_pkg::lane_cmd_t        cmd,
    output msss_pkg::seg_t             pattern
);
    import msss_pkg::*;

    logic              in_use;
    logic [LANE_W-1:0] logical;
    logic [3:0]        nib;
    logic              do_write;
    logic              do_toggle;
    seg_t              pattern_reg;
    seg_t              pattern_next;

    // Map this physical position to its logical digit.
    assign in_use  = int'(lane_idx) < int'(cmd.count);
    assign logical = LANE_W'(int'(cmd.count) - 1 - int'(lane_idx));
    assign nib     = 4'(cmd.bcd >> {logical, 2'b00});

    assign do_write  = cmd.wr && in_use && (int'(logical) < int'(cmd.total))
                       && (int'(logical) < NIBBLES);
    assign do_toggle = cmd.tog && in_use && (int'(logical) >= int'(cmd.rfirst))
                       && (int'(logical) <= int'(cmd.rlast));

    // Next pattern: a write replaces it, a toggle flips the dot.
    always_comb
    begin
        pattern_next = pattern_reg;
        if (do_write)
        begin
            pattern_next = seg_of(nib);
        end
        else if (do_toggle)
        begin
            pattern_next = pattern_reg ^ DOT_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
        end
        else
        begin
            pattern_reg <= pattern_next;
        end
    end

    assign pattern = pattern_reg;

endmodule

// File: design/msss_scan.sv
// ----------------------------------------------------------------------------
// msss_scan: scan position, flash timing and lane merge
// Tracks the active digit and flash phase and picks the active lane's pattern
// for a refresh beat, blanking it in the flash range while the phase is on.
// ----------------------------------------------------------------------------
module msss_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  msss_pkg::scan_ctl_t           ctl,
    input  logic [msss_pkg::CNT_W-1:0]    count,
    input  logic [2:0]                    flash_first,
    input  logic [2:0]                    flash_last,
    input  logic [msss_pkg::PERIOD_W-1:0] flash_period,
    input  msss_pkg::seg_t                patterns [msss_pkg::MAX_DIGITS],
    output logic [2:0]                    digit_select,
    output msss_pkg::seg_t                segments
);
    import msss_pkg::*;

    logic [LANE_W-1:0]   active_reg;
    logic [LANE_W-1:0]   active_next;
    logic [PERIOD_W-1:0] counter_reg;
    logic [PERIOD_W-1:0] counter_next;
    logic                phase_reg;
    logic                phase_next;
    logic [LANE_W-1:0]   act;
    logic [LANE_W-1:0]   logical;
    logic [PERIOD_W-1:0] counter_inc;
    logic                flash_on;
    logic                hide;

    // Current position, clamped to the scanned range.
    assign act     = (int'(active_reg) >= int'(count)) ? LANE_W'(int'(count) - 1)
                                                       : active_reg;
    assign logical = LANE_W'(int'(count) - 1 - int'(act));
    assign flash_on    = flash_period != '0;
    assign counter_inc = counter_reg + PERIOD_W'(1);

    // Flash counter advances once per scan, at digit 0.
    always_comb
    begin
        counter_next = counter_reg;
        phase_next   = phase_reg;
        active_next  = active_reg;
        if (ctl.flash_clr)
        begin
            counter_next = '0;
            phase_next   = 1'b0;
        end
        else if (ctl.step && flash_on && (act == '0))
        begin
            if (counter_inc >= flash_period)
            begin
                counter_next = '0;
                phase_next   = !phase_reg;
            end
            else
            begin
                counter_next = counter_inc;
            end
        end
        if (ctl.count_wr)
        begin
            active_next = LANE_W'(int'(ctl.count_new) - 1);
        end
        else if (ctl.step)
        begin
            active_next = (int'(act) + 1 >= int'(count)) ? '0 : LANE_W'(int'(act) + 1);
        end
    end

    // Merge: select the active lane and blank it when flashing hides it.
    assign hide = flash_on && phase_next && (int'(logical) >= int'(flash_first))
                  && (int'(logical) <= int'(flash_last));
    assign digit_select = 3'(act);
    assign segments     = hide ? '0 : patterns[act];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= LANE_W'(int'(COUNT_RESET) - 1);
            counter_reg <= '0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            counter_reg <= counter_next;
            phase_reg   <= phase_next;
        end
    end

    // The scan position never leaves the scanned range.
    a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(active_reg) < int'(count))
        else $error("active digit outside scanned range");

    // The counter stays below the period while flashing.
    a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        flash_on |-> (counter_reg < flash_period))
        else $error("flash counter reached period");

    // With flashing off the phase never turns on by itself.
    a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!flash_on && !ctl.flash_clr && !phase_reg) |=> !phase_reg)
        else $error("flash phase set while flashing disabled");

endmodule
